/* hdl/eebe_pkg.sv */
package eebe_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned EDGES   = 3;
  localparam int unsigned DIFF_W  = WORD_W + 1;
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  localparam int unsigned AREA_W  = PROD_W + 1;
  localparam int unsigned AMAG_W  = PROD_W;
  localparam int unsigned SUMSQ_W = PROD_W;
  localparam int unsigned ROOT_W  = SUMSQ_W / 2;
  localparam int unsigned QUO_W   = WORD_W;
  // wide enough for the largest shifted numerator over the whole fraction range
  localparam int unsigned NUM_W   = AMAG_W + QUO_W;

  localparam int unsigned SQRT_LAT = ROOT_W;
  localparam int unsigned DIV_LAT  = QUO_W + 2;

  localparam int unsigned IN_W  = 8 * WORD_W;
  localparam int unsigned RES_W = 9 * WORD_W;

  typedef struct packed {
    logic [EDGES-1:0][1:0][DIFF_W-1:0] tmag;
    logic [EDGES-1:0][1:0]             tneg;
    logic [EDGES-1:0]                  lneg;
    logic                              aneg;
    logic [AMAG_W-1:0]                 amag;
    logic                              deg;
  } side_t;

  typedef struct packed {
    logic             deg;
    logic [RES_W-1:0] data;
  } res_t;

  function automatic logic signed [DIFF_W-1:0] sdiff(logic [WORD_W-1:0] a,
                                                      logic [WORD_W-1:0] b);
    return $signed({a[WORD_W-1], a}) - $signed({b[WORD_W-1], b});
  endfunction

  function automatic logic [DIFF_W-1:0] smag(logic signed [DIFF_W-1:0] a);
    return a[DIFF_W-1] ? DIFF_W'(-a) : DIFF_W'(a);
  endfunction

endpackage

/* hdl/eebe_front.sv */
module eebe_front (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  logic                                                 en,
  input  logic                                                 in_valid,
  input  logic [eebe_pkg::IN_W-1:0]                            in_data,
  output logic                                                 out_valid,
  output logic [eebe_pkg::EDGES-1:0][eebe_pkg::SUMSQ_W-1:0]    out_sumsq,
  output eebe_pkg::side_t                                      out_side
);

  localparam int unsigned W = eebe_pkg::WORD_W;
  localparam int unsigned D = eebe_pkg::DIFF_W;
  localparam int unsigned P = eebe_pkg::PROD_W;
  localparam int unsigned A = eebe_pkg::AREA_W;
  localparam int unsigned E = eebe_pkg::EDGES;

  typedef logic signed [D-1:0] diff_t;
  typedef logic signed [P-1:0] prod_t;

  logic [W-1:0]        px, py;
  logic [E-1:0][W-1:0] vx, vy;

  assign px = in_data[0 +: W];
  assign py = in_data[W +: W];

  always_comb begin
    for (int k = 0; k < E; k++) begin
      vx[k] = in_data[(2 + 2 * k) * W +: W];
      vy[k] = in_data[(3 + 2 * k) * W +: W];
    end
  end

  // stage 1: differences
  logic  v1;
  diff_t ax, ay, bx, by;
  diff_t dx [E];
  diff_t dy [E];
  diff_t tx [E];
  diff_t ty [E];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      ax <= eebe_pkg::sdiff(vx[1], vx[0]);
      ay <= eebe_pkg::sdiff(vy[1], vy[0]);
      bx <= eebe_pkg::sdiff(vx[2], vx[0]);
      by <= eebe_pkg::sdiff(vy[2], vy[0]);
      for (int e = 0; e < E; e++) begin
        dx[e] <= eebe_pkg::sdiff(vx[(e + 1) % E], vx[(e + 2) % E]);
        dy[e] <= eebe_pkg::sdiff(vy[(e + 1) % E], vy[(e + 2) % E]);
        tx[e] <= eebe_pkg::sdiff(vy[e], py);
        ty[e] <= eebe_pkg::sdiff(px, vx[e]);
      end
    end
  end

  // stage 2: products, magnitudes and edge signs
  logic            v2;
  prod_t           p1, p2;
  prod_t           sqx [E];
  prod_t           sqy [E];
  eebe_pkg::side_t side2_next, side2;

  always_comb begin
    side2_next = '0;
    for (int e = 0; e < E; e++) begin
      side2_next.tmag[e][0] = eebe_pkg::smag(tx[e]);
      side2_next.tmag[e][1] = eebe_pkg::smag(ty[e]);
      side2_next.tneg[e][0] = tx[e][D-1];
      side2_next.tneg[e][1] = ty[e][D-1];
      // larger component decides the sign, y on a tie
      side2_next.lneg[e] = (eebe_pkg::smag(dx[e]) > eebe_pkg::smag(dy[e])) ?
                           dx[e][D-1] : dy[e][D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      p1    <= P'(ax) * P'(by);
      p2    <= P'(ay) * P'(bx);
      side2 <= side2_next;
      for (int e = 0; e < E; e++) begin
        sqx[e] <= P'(dx[e]) * P'(dx[e]);
        sqy[e] <= P'(dy[e]) * P'(dy[e]);
      end
    end
  end

  // stage 3: doubled area and squared lengths
  logic                                        v3;
  logic signed [A-1:0]                         area;
  logic [E-1:0][eebe_pkg::SUMSQ_W-1:0]         sumsq3;
  eebe_pkg::side_t                             side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      area  <= $signed({p1[P-1], p1}) - $signed({p2[P-1], p2});
      side3 <= side2;
      for (int e = 0; e < E; e++) begin
        sumsq3[e] <= $unsigned(sqx[e]) + $unsigned(sqy[e]);
      end
    end
  end

  // stage 4: area magnitude and zero test
  eebe_pkg::side_t side4_next;

  always_comb begin
    side4_next      = side3;
    side4_next.aneg = area[A-1];
    side4_next.amag = eebe_pkg::AMAG_W'(area[A-1] ? -area : area);
    side4_next.deg  = (area == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v3;
    if (en) begin
      out_side  <= side4_next;
      out_sumsq <= sumsq3;
    end
  end

endmodule

/* hdl/eebe_isqrt.sv */
module eebe_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [eebe_pkg::SUMSQ_W-1:0]  in_sumsq,
  output logic                          out_valid,
  output logic [eebe_pkg::ROOT_W-1:0]   out_root
);

  localparam int unsigned N = eebe_pkg::ROOT_W;
  localparam int unsigned S = eebe_pkg::SUMSQ_W;
  localparam int unsigned R = N + 2;

  logic [N-1:0] v_q;
  logic [S-1:0] s_q     [N];
  logic [R-1:0] rem_q   [N];
  logic [N-1:0] root_q  [N];
  logic [S-1:0] s_in    [N];
  logic [R-1:0] rem_in  [N];
  logic [N-1:0] root_in [N];
  logic [R-1:0] rem_nx  [N];
  logic [N-1:0] root_nx [N];

  // one result bit per stage, two radicand bits shifted in each time
  always_comb begin
    logic [R+1:0] cur;
    logic [R+1:0] trial;
    logic         ge;
    for (int k = 0; k < N; k++) begin
      s_in[k]    = (k == 0) ? in_sumsq : s_q[k-1];
      rem_in[k]  = (k == 0) ? '0 : rem_q[k-1];
      root_in[k] = (k == 0) ? '0 : root_q[k-1];
      cur        = {rem_in[k], s_in[k][S-1-2*k -: 2]};
      trial      = (R + 2)'({root_in[k], 2'b01});
      ge         = (cur >= trial);
      rem_nx[k]  = R'(ge ? cur - trial : cur);
      root_nx[k] = {root_in[k][N-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_q <= '0;
    else if (en) v_q <= {v_q[N-2:0], in_valid};
    if (en) begin
      for (int k = 0; k < N; k++) begin
        s_q[k]    <= s_in[k];
        rem_q[k]  <= rem_nx[k];
        root_q[k] <= root_nx[k];
      end
    end
  end

  assign out_valid = v_q[N-1];
  assign out_root  = root_q[N-1];

endmodule

/* hdl/eebe_div.sv */
module eebe_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_neg,
  input  logic [eebe_pkg::NUM_W-1:0]    in_num,
  input  logic [eebe_pkg::AMAG_W-1:0]   in_den,
  output logic                          out_valid,
  output logic [eebe_pkg::QUO_W-1:0]    out_quo
);

  localparam int unsigned Q  = eebe_pkg::QUO_W;
  localparam int unsigned DW = eebe_pkg::AMAG_W;
  localparam int unsigned NW = eebe_pkg::NUM_W;

  localparam logic [Q-1:0] SAT_POS = {1'b0, {(Q - 1){1'b1}}};
  localparam logic [Q-1:0] SAT_NEG = {1'b1, {(Q - 1){1'b0}}};

  logic [Q+1:0]  v_q;
  logic [DW-1:0] r_q   [Q+1];
  logic [DW-1:0] den_q [Q+1];
  logic [Q-1:0]  lo_q  [Q+1];
  logic [Q-1:0]  q_q   [Q+1];
  logic          neg_q [Q+1];
  logic          ovf_q [Q+1];
  logic [DW-1:0] r_nx  [Q+1];
  logic [Q-1:0]  q_nx  [Q+1];

  // stage 0 flags a quotient of 2^Q or more; stages 1..Q produce one bit each
  always_comb begin
    logic [DW:0] cur;
    logic        ge;
    r_nx[0] = in_num[NW-1:Q];
    q_nx[0] = '0;
    for (int k = 1; k <= Q; k++) begin
      cur     = {r_q[k-1], lo_q[k-1][Q-k]};
      ge      = (cur >= {1'b0, den_q[k-1]});
      r_nx[k] = DW'(ge ? cur - {1'b0, den_q[k-1]} : cur);
      q_nx[k] = {q_q[k-1][Q-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v_q <= '0;
    else if (en) v_q <= {v_q[Q:0], in_valid};
    if (en) begin
      r_q[0]   <= r_nx[0];
      q_q[0]   <= q_nx[0];
      den_q[0] <= in_den;
      lo_q[0]  <= in_num[Q-1:0];
      neg_q[0] <= in_neg;
      ovf_q[0] <= (in_num[NW-1:Q] >= in_den);
      for (int k = 1; k <= Q; k++) begin
        r_q[k]   <= r_nx[k];
        q_q[k]   <= q_nx[k];
        den_q[k] <= den_q[k-1];
        lo_q[k]  <= lo_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
      // apply sign and clamp
      if (neg_q[Q]) begin
        out_quo <= (ovf_q[Q] || q_q[Q] > SAT_NEG) ? SAT_NEG : Q'(-q_q[Q]);
      end else begin
        out_quo <= (ovf_q[Q] || q_q[Q][Q-1]) ? SAT_POS : q_q[Q];
      end
    end
  end

  assign out_valid = v_q[Q+1];

endmodule

/* hdl/eebe_skid.sv */
module eebe_skid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  eebe_pkg::res_t              in_word,
  output logic                        full,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [eebe_pkg::RES_W-1:0]  out_data,
  output logic                        out_flag
);

  eebe_pkg::res_t word_q, skid_q;
  logic           take;

  assign take = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      full      <= 1'b0;
    end else begin
      priority if (full) begin
        if (take) full <= 1'b0;
      end else if (in_valid && out_valid && !take) begin
        full <= 1'b1;
      end else if (in_valid) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (full) begin
      if (take) word_q <= skid_q;
    end else if (in_valid) begin
      if (out_valid && !take) skid_q <= in_word;
      else word_q <= in_word;
    end
  end

  assign out_data = word_q.data;
  assign out_flag = word_q.deg;

  a_full_has_out: assert property (@(posedge clk) disable iff (rst)
    full |-> out_valid) else $error("skid holds a word with the output empty");

  a_stall_fills: assert property (@(posedge clk) disable iff (rst)
    (!full && in_valid && out_valid && !take) |=> full)
    else $error("stalled word not captured in skid");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (full && take) |=> (!full && out_valid))
    else $error("skid word lost on drain");

endmodule

/* hdl/edge_element_basis_eval.sv */
// Edge element basis evaluator: lowest-order edge basis on a triangle at one point.
//
// Input channel s_*: one word per point, eight signed fixed-point coordinates
// (point, then vertices 0, 1, 2). Output channel m_*: three basis vectors and
// three curls, each saturated to 32 bits, plus a degenerate flag in m_tuser that
// marks a zero-area triangle; its data is then all zeros.
//
// Throughput: one word per cycle while the skid is empty. The pipeline is made of
// four front stages (differences, products, area), a 33-stage square root (one
// result bit per stage), one multiply stage, and a 34-stage divider per output
// (overflow check, one quotient bit per stage, clamp), then the output register.
//
// The pipeline advances as a whole. An output register plus a one-word skid
// buffer part it from the receiver: when the receiver stalls, the next word
// lands in the skid and the pipeline freezes with s_tready low until the skid
// drains. Nothing is dropped or repeated.
//
// Reset (rst, synchronous) clears all valid bits and the skid full flag; no clearing
// pass is needed, the block takes words on the cycle after reset.
module edge_element_basis_eval #(
  parameter int unsigned FRAC_BITS = eebe_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // point_x, point_y, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y
  input  logic [eebe_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // basis1_x, basis1_y, basis2_x, basis2_y, basis3_x, basis3_y, curl1, curl2, curl3
  output logic [eebe_pkg::RES_W-1:0]  m_tdata,
  // degenerate
  output logic                        m_tuser
);

  localparam int unsigned W = eebe_pkg::WORD_W;
  localparam int unsigned E = eebe_pkg::EDGES;
  localparam int unsigned L = eebe_pkg::SQRT_LAT;
  localparam int unsigned V = eebe_pkg::DIV_LAT;

  logic en;
  logic full;

  // freeze the pipeline while the skid holds a word
  assign en       = ~full;
  assign s_tready = en;

  // front stages
  logic                                       fr_valid;
  logic [E-1:0][eebe_pkg::SUMSQ_W-1:0]        fr_sumsq;
  eebe_pkg::side_t                            fr_side;

  eebe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (fr_valid),
    .out_sumsq (fr_sumsq),
    .out_side  (fr_side)
  );

  // edge lengths, one root unit per edge
  logic [E-1:0]                       sq_valid;
  logic [E-1:0][eebe_pkg::ROOT_W-1:0] sq_root;

  for (genvar e = 0; e < E; e++) begin : g_root
    eebe_isqrt u_isqrt (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (fr_valid),
      .in_sumsq  (fr_sumsq[e]),
      .out_valid (sq_valid[e]),
      .out_root  (sq_root[e])
    );
  end

  // carry the side data alongside the root pipeline
  eebe_pkg::side_t side_q [L];

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= fr_side;
      for (int k = 1; k < L; k++) side_q[k] <= side_q[k-1];
    end
  end

  // length times opposite-vertex offset
  logic                                            m_valid;
  logic [E-1:0][1:0][eebe_pkg::PROD_W-1:0]         m_prod;
  logic [E-1:0][eebe_pkg::ROOT_W-1:0]              m_root;
  eebe_pkg::side_t                                 m_side;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= &sq_valid;
    if (en) begin
      m_root <= sq_root;
      m_side <= side_q[L-1];
      for (int e = 0; e < E; e++) begin
        m_prod[e][0] <= eebe_pkg::PROD_W'(sq_root[e]) *
                        eebe_pkg::PROD_W'(side_q[L-1].tmag[e][0]);
        m_prod[e][1] <= eebe_pkg::PROD_W'(sq_root[e]) *
                        eebe_pkg::PROD_W'(side_q[L-1].tmag[e][1]);
      end
    end
  end

  // nine dividers sharing the area magnitude
  logic [8:0]        div_valid;
  logic [8:0][W-1:0] quo_all;

  for (genvar e = 0; e < E; e++) begin : g_edge
    for (genvar c = 0; c < 3; c++) begin : g_part
      logic [eebe_pkg::NUM_W-1:0] num;
      logic                       neg;
      if (c < 2) begin : g_basis
        assign num = eebe_pkg::NUM_W'(m_prod[e][c]) << FRAC_BITS;
        assign neg = m_side.lneg[e] ^ m_side.tneg[e][c] ^ m_side.aneg;
      end else begin : g_curl
        assign num = eebe_pkg::NUM_W'(m_root[e]) << (2 * FRAC_BITS);
        assign neg = m_side.lneg[e] ^ m_side.aneg;
      end
      eebe_div u_div (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .in_valid  (m_valid),
        .in_neg    (neg),
        .in_num    (num),
        .in_den    (m_side.amag),
        .out_valid (div_valid[3 * e + c]),
        .out_quo   (quo_all[(c == 2) ? 6 + e : 2 * e + c])
      );
    end
  end

  // degenerate flag follows the dividers
  logic [V-1:0] deg_q;

  always_ff @(posedge clk) begin
    if (en) deg_q <= {deg_q[V-2:0], m_side.deg};
  end

  // zero-area triangle forces zero data
  eebe_pkg::res_t res;

  always_comb begin
    res.deg  = deg_q[V-1];
    res.data = deg_q[V-1] ? '0 : quo_all;
  end

  eebe_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (&div_valid),
    .in_word   (res),
    .full      (full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_flag  (m_tuser)
  );

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("degenerate word carries nonzero data");

endmodule

/* dv/tb_edge_element_basis_eval.sv */
module tb_edge_element_basis_eval;

  localparam int unsigned FB        = eebe_pkg::FRAC_BITS_DEF;
  localparam int          N_RANDOM  = 1136;
  localparam int          QUIET_TAIL = 150;   // no idling over the last words
  localparam int          DOG_LIMIT = 4000;   // cycles without any accept
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  typedef logic [7:0][31:0] point_word_t;   // px, py, v0x, v0y, v1x, v1y, v2x, v2y

  typedef struct packed {
    logic             deg;
    logic [8:0][31:0] val;   // basis1_x .. basis3_y, curl1 .. curl3
  } basis_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [eebe_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [eebe_pkg::RES_W-1:0] m_tdata;
  logic m_tuser;
  // travels with the word on s_tdata: expect a collapsed-triangle result
  logic typed_deg = 1'b0;

  basis_res_t expected_q[$];
  int  mismatches = 0;
  int  n_checked = 0;
  int  n_degen = 0;
  int  n_sat = 0;
  bit  quiet = 1'b0;
  int  idle_cycles = 0;

  edge_element_basis_eval i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact wide integer arithmetic, truncation toward zero, then clamp.
  // ---------------------------------------------------------------------------
  function automatic logic [127:0] mag(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (128'(1) << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [31:0] div_clamp(bit neg, logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = num / den;
    if (neg) begin
      if (q > 128'h8000_0000) return SMIN;
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) return SMAX;
    return q[31:0];
  endfunction

  function automatic basis_res_t eval_basis(point_word_t w);
    longint px, py, dx, dy, tx, ty;
    longint vx[3], vy[3];
    logic signed [127:0] ea, eb, ec, ed, area;
    logic [127:0] amag, lmag;
    bit aneg, lneg;
    int a, b;
    basis_res_t r;
    r = '0;
    px = $signed(w[0]);
    py = $signed(w[1]);
    for (int i = 0; i < 3; i++) begin
      vx[i] = $signed(w[2 + 2 * i]);
      vy[i] = $signed(w[3 + 2 * i]);
    end
    ea = vx[1] - vx[0];
    eb = vy[2] - vy[0];
    ec = vy[1] - vy[0];
    ed = vx[2] - vx[0];
    area = ea * eb - ec * ed;
    if (area == 0) begin
      r.deg = 1'b1;
      return r;
    end
    aneg = area < 0;
    amag = aneg ? 128'(-area) : 128'(area);
    for (int e = 0; e < 3; e++) begin
      a = (e + 1) % 3;
      b = (e + 2) % 3;
      dx = vx[a] - vx[b];
      dy = vy[a] - vy[b];
      tx = vy[e] - py;
      ty = px - vx[e];
      lmag = root_floor(mag(dx) * mag(dx) + mag(dy) * mag(dy));
      // sign follows the larger component; y wins a tie
      lneg = mag(dx) > mag(dy) ? dx < 0 : dy < 0;
      r.val[2 * e]     = div_clamp(lneg ^ (tx < 0) ^ aneg, (lmag * mag(tx)) << FB, amag);
      r.val[2 * e + 1] = div_clamp(lneg ^ (ty < 0) ^ aneg, (lmag * mag(ty)) << FB, amag);
      r.val[6 + e]     = div_clamp(lneg ^ aneg, lmag << (2 * FB), amag);
    end
    return r;
  endfunction

  function automatic point_word_t pack_pt(logic [31:0] px, logic [31:0] py,
                                          logic [31:0] x0, logic [31:0] y0,
                                          logic [31:0] x1, logic [31:0] y1,
                                          logic [31:0] x2, logic [31:0] y2);
    return {y2, x2, y1, x1, y0, x0, py, px};
  endfunction

  function automatic logic [31:0] near(int span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Mostly compact triangles, some full-range noise, some collapsed ones.
  function automatic point_word_t rand_point();
    int kind;
    logic [31:0] bx, by, ux, uy;
    point_word_t w;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      for (int i = 0; i < 8; i++) w[i] = $urandom;
    end else if (kind == 2) begin
      bx = near(1 << 22); by = near(1 << 22);
      ux = near(1 << 18); uy = near(1 << 18);
      if ($urandom_range(0, 1))
        w = pack_pt(near(1 << 24), near(1 << 24), bx, by, bx + ux, by + uy, bx, by);
      else
        w = pack_pt($urandom, $urandom, bx, by, bx + ux, by + uy,
                    bx + 2 * ux, by + 2 * uy);
    end else begin
      bx = near(1 << 24); by = near(1 << 24);
      w = pack_pt(bx + near(1 << 20), by + near(1 << 20),
                  bx + near(1 << 20), by + near(1 << 20),
                  bx + near(1 << 20), by + near(1 << 20),
                  bx + near(1 << 20), by + near(1 << 20));
    end
    return w;
  endfunction

  // Record the expectation for every word the block takes.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (typed_deg) expected_q.push_back(basis_res_t'{deg: 1'b1, val: '0});
      else expected_q.push_back(eval_basis(s_tdata));
    end
  end

  // Receiver: stall in random bursts, never once the tail is reached.
  int rx_hold = 0;
  always @(posedge clk) begin
    if (quiet) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      rx_hold <= $urandom_range(1, 19);
    end else begin
      m_tready <= 1'b1;
      rx_hold <= $urandom_range(0, 30);
    end
  end

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    basis_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (expected_q.size() == 0) begin
        $display("%0t: result word expected none actual %h", $time, got);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (want.deg) n_degen++;
        for (int i = 0; i < 9; i++) begin
          if (want.val[i] == SMAX || want.val[i] == SMIN) n_sat++;
          if (got.val[i] !== want.val[i]) begin
            $display("%0t: field %0d expected %h actual %h", $time, i, want.val[i],
                     got.val[i]);
            mismatches++;
          end
        end
        if (got.deg !== want.deg) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.deg, got.deg);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= DOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("tb_edge_element_basis_eval: errors");
        $finish;
      end
    end
  end

  // Send one word; hold off in random bursts first unless in the tail.
  task automatic send_word(point_word_t w);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  point_word_t directed[$];
  bit          directed_deg[$];

  initial begin
    // Collapsed triangles carry a typed result: flag set, all data zero.
    directed.push_back(pack_pt(0, 0, 0, 0, 0, 0, 0, 0));               directed_deg.push_back(1);
    directed.push_back(pack_pt(SMIN, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
    directed_deg.push_back(1);
    directed.push_back(pack_pt(ONE, 0, 0, 0, ONE, ONE, 2 * ONE, 2 * ONE));
    directed_deg.push_back(1);
    // zero-length edge: v1 on v2
    directed.push_back(pack_pt(SMAX, SMIN, SMIN, SMIN, SMAX, 0, SMAX, 0));
    directed_deg.push_back(1);
    // unit triangle, both orientations
    directed.push_back(pack_pt(ONE / 4, ONE / 4, 0, 0, ONE, 0, 0, ONE));
    directed_deg.push_back(0);
    directed.push_back(pack_pt(ONE / 4, ONE / 4, 0, 0, 0, ONE, ONE, 0));
    directed_deg.push_back(0);
    // full-scale corners
    directed.push_back(pack_pt(SMIN, SMIN, SMIN, SMIN, SMAX, SMIN, SMIN, SMAX));
    directed_deg.push_back(0);
    directed.push_back(pack_pt(SMAX, SMAX, SMAX, SMAX, SMIN, SMAX, SMAX, SMIN));
    directed_deg.push_back(0);
    // sliver (long edges, small area) and smallest triangle: curls clamp
    directed.push_back(pack_pt(SMAX, SMIN, 0, 0, SMAX, 0, SMAX, 1));
    directed_deg.push_back(0);
    directed.push_back(pack_pt(SMIN, SMAX, 0, 0, 1, 0, 0, 1));
    directed_deg.push_back(0);
    // edges with equal component magnitudes (all but the middle word)
    directed.push_back(pack_pt(0, 0, 0, 0, ONE, ONE, -ONE, ONE));
    directed_deg.push_back(0);
    directed.push_back(pack_pt(32'hFFFF_FFFF, 1, -ONE, -ONE, ONE, -ONE, 0, ONE));
    directed_deg.push_back(0);
    directed.push_back(pack_pt(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                               32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_3333, 32'hCCCC_CCCC));
    directed_deg.push_back(0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      typed_deg <= directed_deg[i];
      send_word(directed[i]);
    end
    typed_deg <= 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - QUIET_TAIL) quiet = 1'b1;
      send_word(rand_point());
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d points checked (%0d directed), %0d degenerate, %0d clamped fields",
             n_checked, directed.size(), n_degen, n_sat);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_edge_element_basis_eval: clean");
    end else begin
      $display("tb_edge_element_basis_eval: errors");
    end
    $finish;
  end

endmodule
